### rtl/thp_sc_pkg.sv
package thp_sc_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned DivSteps    = 64;
  localparam int unsigned FrontStages = 12;
  localparam int unsigned BackStages  = 5;
  localparam int unsigned PipeStages  = FrontStages + DivSteps + BackStages;
  localparam int unsigned Latency     = PipeStages + 1;

  localparam logic signed [31:0] HumOffset   = 32'sd76800;
  localparam logic        [31:0] HumRound    = 32'd16384;
  localparam logic signed [31:0] HumBias     = 32'sd2097152;
  localparam logic signed [31:0] HumMax      = 32'sd419430400;
  localparam logic        [16:0] HumMaxQ10   = 17'd102400;
  localparam logic signed [33:0] PressOffset = 34'sd128000;
  localparam logic        [20:0] PressBase   = 21'd1048576;
  localparam logic signed [63:0] PressScale  = 64'sd3125;
  localparam logic signed [63:0] PressBias47 = 64'sh0000_8000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTemp   = 3'd0,
    CfgPressA = 3'd1,
    CfgPressB = 3'd2,
    CfgPressC = 3'd3,
    CfgHumidA = 3'd4,
    CfgHumidB = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] temp_raw;
    logic [19:0] press_raw;
    logic [15:0] humid_raw;
  } thp_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic        [16:0] humidity_q10;
    logic        [31:0] pressure_q8;
    logic               pressure_div_zero;
  } thp_out_t;

endpackage

### rtl/thp_sensor_compensation_unit.sv
// Integer compensation of raw temperature, pressure and humidity readings.
// Input channel: a beat of in_item_i is taken at each rising edge where
// start is high and busy is low. busy is always low, so a new triple may be
// offered in every cycle.
// Output channel: result_valid_o marks a result beat on result_o for exactly
// one cycle; the receiver cannot stall, so results are never held back.
// Throughput is one triple per cycle. The pipeline depth is set by the
// 64-stage restoring divider of the pressure path, one quotient bit per
// stage, plus twelve stages before it and five after it, followed by the
// registered output.
// Configuration: cfg_we_i writes cfg_wdata_i into the calibration register
// selected by cfg_idx_i in the same edge; unknown indexes are ignored.
// Calibration may change only while no beat is in flight.
// Reset clears the calibration registers and every valid bit in flight.
module thp_sensor_compensation_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  thp_sc_pkg::thp_in_t                 in_item_i,
  input  logic                                cfg_we_i,
  input  logic [thp_sc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [thp_sc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                                result_valid_o,
  output thp_sc_pkg::thp_out_t                result_o
);
  import thp_sc_pkg::*;

  typedef struct packed {
    logic [63:0] an;
    logic [63:0] ad;
    logic        neg;
    logic        dz;
  } div_in_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic        [16:0] hum;
    logic               neg;
    logic               dz;
  } side_t;

  logic [47:0] temp_coeffs_q, press_a_q, press_b_q, press_c_q;
  logic [31:0] humid_a_q;
  logic [39:0] humid_b_q;

  logic        [15:0] ct1, cp1;
  logic signed [15:0] ct2, ct3, cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9, ch2, ch4, ch5;
  logic        [7:0]  ch1, ch3;
  logic signed [7:0]  ch6;
  logic signed [63:0] p4x, p7x;

  assign ct1 = temp_coeffs_q[15:0];
  assign ct2 = $signed(temp_coeffs_q[31:16]);
  assign ct3 = $signed(temp_coeffs_q[47:32]);
  assign cp1 = press_a_q[15:0];
  assign cp2 = $signed(press_a_q[31:16]);
  assign cp3 = $signed(press_a_q[47:32]);
  assign cp4 = $signed(press_b_q[15:0]);
  assign cp5 = $signed(press_b_q[31:16]);
  assign cp6 = $signed(press_b_q[47:32]);
  assign cp7 = $signed(press_c_q[15:0]);
  assign cp8 = $signed(press_c_q[31:16]);
  assign cp9 = $signed(press_c_q[47:32]);
  assign ch1 = humid_a_q[7:0];
  assign ch2 = $signed(humid_a_q[23:8]);
  assign ch3 = humid_a_q[31:24];
  assign ch4 = $signed(humid_b_q[15:0]);
  assign ch5 = $signed(humid_b_q[31:16]);
  assign ch6 = $signed(humid_b_q[39:32]);
  assign p4x = 64'(cp4);
  assign p7x = 64'(cp7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_c_q     <= '0;
      humid_a_q     <= '0;
      humid_b_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTemp:   temp_coeffs_q <= cfg_wdata_i;
        CfgPressA: press_a_q     <= cfg_wdata_i;
        CfgPressB: press_b_q     <= cfg_wdata_i;
        CfgPressC: press_c_q     <= cfg_wdata_i;
        CfgHumidA: humid_a_q     <= cfg_wdata_i[31:0];
        CfgHumidB: humid_b_q     <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  logic [PipeStages-1:0] vld_q;
  logic                  out_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[PipeStages-2:0], start & ~busy};
      out_vld_q <= vld_q[PipeStages-1];
    end
  end

  logic signed [18:0] te;
  logic signed [16:0] td;
  assign te = $signed({2'b00, in_item_i.temp_raw[19:3]}) - $signed({2'b00, ct1, 1'b0});
  assign td = $signed({1'b0, in_item_i.temp_raw[19:4]}) - $signed({1'b0, ct1});

  logic        [19:0] adcp_q [1:7];
  logic        [15:0] adch_q [1:5];
  logic signed [31:0] temp_q [5:12];
  logic signed [31:0] left_q [6:8];
  logic signed [31:0] v2_q   [9:11];
  logic signed [31:0] s1_ta_q, s1_dsq_q, s2_a_q, s2_bm_q, s3_fine_q;
  logic signed [31:0] s4_t5_q, s4_v_q;
  logic signed [33:0] s4_x1_q;
  logic signed [31:0] s5_h5v_q, s5_vh6_q, s5_vh3_q;
  logic signed [63:0] s5_xsq_q, s5_x1p5_q, s5_x1p2_q;
  logic signed [31:0] s6_ip_q;
  logic signed [63:0] s6_x2a_q, s6_x1a_q, s6_x1p5_q, s6_x1p2_q;
  logic signed [31:0] s7_rp_q;
  logic signed [63:0] s7_x2_q, s7_x1b_q;
  logic signed [31:0] s8_right_q;
  logic signed [63:0] s8_pp_q, s8_nn_q;
  logic signed [63:0] s9_den_q, s9_num_q;
  logic signed [31:0] s10_ss_q, s11_hs_q;
  div_in_t            s10_div_q, s11_div_q, s12_div_q;
  logic        [16:0] s12_hum_q;

  logic        [31:0] h_lsum;
  logic        [20:0] p_diff;
  logic signed [31:0] s9_s, h_v3;
  logic        [16:0] h_hum;

  assign h_lsum = {2'b00, adch_q[5], 14'd0} - {ch4[11:0], 20'd0} - s5_h5v_q + HumRound;
  assign p_diff = PressBase - {1'b0, adcp_q[7]};
  assign s9_s   = v2_q[9] >>> 15;
  assign h_v3   = v2_q[11] - (s11_hs_q >>> 4);

  always_comb begin
    if (h_v3[31]) begin
      h_hum = '0;
    end else if (h_v3 > HumMax) begin
      h_hum = HumMaxQ10;
    end else begin
      h_hum = h_v3[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    adcp_q[1] <= in_item_i.press_raw;
    adch_q[1] <= in_item_i.humid_raw;
    for (int k = 2; k <= 7; k++) adcp_q[k] <= adcp_q[k-1];
    for (int k = 2; k <= 5; k++) adch_q[k] <= adch_q[k-1];
    for (int k = 6; k <= 12; k++) temp_q[k] <= temp_q[k-1];
    left_q[7] <= left_q[6];
    left_q[8] <= left_q[7];
    v2_q[10]  <= v2_q[9];
    v2_q[11]  <= v2_q[10];

    s1_ta_q  <= 32'(te) * 32'(ct2);
    s1_dsq_q <= 32'(td) * 32'(td);

    s2_a_q  <= s1_ta_q >>> 11;
    s2_bm_q <= 32'((s1_dsq_q >>> 12) * ct3);

    s3_fine_q <= s2_a_q + (s2_bm_q >>> 14);

    s4_t5_q <= (s3_fine_q <<< 2) + s3_fine_q + 32'sd128;
    s4_v_q  <= s3_fine_q - HumOffset;
    s4_x1_q <= 34'(s3_fine_q) - PressOffset;

    temp_q[5] <= s4_t5_q >>> 8;
    s5_h5v_q  <= 32'(ch5 * s4_v_q);
    s5_vh6_q  <= 32'(s4_v_q * ch6);
    s5_vh3_q  <= 32'(s4_v_q * $signed({1'b0, ch3}));
    s5_xsq_q  <= 64'(s4_x1_q) * 64'(s4_x1_q);
    s5_x1p5_q <= 64'(s4_x1_q) * 64'(cp5);
    s5_x1p2_q <= 64'(s4_x1_q) * 64'(cp2);

    left_q[6] <= $signed(h_lsum) >>> 15;
    s6_ip_q   <= 32'((s5_vh6_q >>> 10) * ((s5_vh3_q >>> 11) + 32'sd32768));
    s6_x2a_q  <= 64'(s5_xsq_q * cp6);
    s6_x1a_q  <= 64'(s5_xsq_q * cp3);
    s6_x1p5_q <= s5_x1p5_q;
    s6_x1p2_q <= s5_x1p2_q;

    s7_rp_q  <= 32'(((s6_ip_q >>> 10) + HumBias) * ch2);
    s7_x2_q  <= s6_x2a_q + (s6_x1p5_q <<< 17) + (p4x <<< 35);
    s7_x1b_q <= (s6_x1a_q >>> 8) + (s6_x1p2_q <<< 12);

    s8_right_q <= (s7_rp_q + 32'sd8192) >>> 14;
    s8_pp_q    <= 64'((PressBias47 + s7_x1b_q) * $signed({1'b0, cp1}));
    s8_nn_q    <= $signed({12'd0, p_diff, 31'd0}) - s7_x2_q;

    v2_q[9]  <= 32'(left_q[8] * s8_right_q);
    s9_den_q <= s8_pp_q >>> 33;
    s9_num_q <= 64'(s8_nn_q * PressScale);

    s10_ss_q      <= 32'(s9_s * s9_s);
    s10_div_q.an  <= s9_num_q[63] ? 64'(-s9_num_q) : s9_num_q;
    s10_div_q.ad  <= s9_den_q[63] ? 64'(-s9_den_q) : s9_den_q;
    s10_div_q.neg <= s9_num_q[63] ^ s9_den_q[63];
    s10_div_q.dz  <= (s9_den_q == '0);

    s11_hs_q  <= 32'((s10_ss_q >>> 7) * $signed({1'b0, ch1}));
    s11_div_q <= s10_div_q;

    s12_hum_q <= h_hum;
    s12_div_q <= s11_div_q;
  end

  logic [63:0] drem_q [DivSteps];
  logic [63:0] dquo_q [DivSteps];
  logic [63:0] dden_q [DivSteps];
  side_t       dsb_q  [DivSteps];

  for (genvar gi = 0; gi < DivSteps; gi++) begin : g_div
    logic [63:0] rem_in, quo_in, den_in;
    side_t       sb_in;
    logic [64:0] rem_t;
    logic        ge;

    if (gi == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = s12_div_q.an;
      assign den_in = s12_div_q.ad;
      assign sb_in  = '{temp: temp_q[12], hum: s12_hum_q,
                        neg: s12_div_q.neg, dz: s12_div_q.dz};
    end else begin : g_next
      assign rem_in = drem_q[gi-1];
      assign quo_in = dquo_q[gi-1];
      assign den_in = dden_q[gi-1];
      assign sb_in  = dsb_q[gi-1];
    end

    assign rem_t = {rem_in, quo_in[63]};
    assign ge    = (rem_t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      drem_q[gi] <= ge ? 64'(rem_t - {1'b0, den_in}) : rem_t[63:0];
      dquo_q[gi] <= {quo_in[62:0], ge};
      dden_q[gi] <= den_in;
      dsb_q[gi]  <= sb_in;
    end
  end

  side_t              post_sb_q [1:BackStages];
  logic signed [63:0] r1_p_q, r2_p_q, r3_p_q, r4_p_q;
  logic        [63:0] r2_qll_q, r3_qq_q;
  logic        [31:0] r2_qhl_q;
  logic signed [63:0] r2_pp8_q, r3_pp8_q, r4_y1p_q, r4_y2_q, r5_sum_q;
  logic signed [63:0] r1_shr;
  thp_out_t           result_q;

  assign r1_shr = r1_p_q >>> 13;

  always_ff @(posedge clk_i) begin
    post_sb_q[1] <= dsb_q[DivSteps-1];
    for (int k = 2; k <= BackStages; k++) post_sb_q[k] <= post_sb_q[k-1];

    r1_p_q <= dsb_q[DivSteps-1].neg ? $signed(64'(-dquo_q[DivSteps-1]))
                                     : $signed(dquo_q[DivSteps-1]);

    r2_qll_q <= {32'd0, r1_shr[31:0]} * {32'd0, r1_shr[31:0]};
    r2_qhl_q <= 32'(r1_shr[63:32] * r1_shr[31:0]);
    r2_pp8_q <= 64'(r1_p_q * cp8);
    r2_p_q   <= r1_p_q;

    r3_qq_q  <= r2_qll_q + {r2_qhl_q[30:0], 33'd0};
    r3_pp8_q <= r2_pp8_q;
    r3_p_q   <= r2_p_q;

    r4_y1p_q <= 64'($signed(r3_qq_q) * cp9);
    r4_y2_q  <= r3_pp8_q >>> 19;
    r4_p_q   <= r3_p_q;

    r5_sum_q <= r4_p_q + (r4_y1p_q >>> 25) + r4_y2_q;

    result_q.temperature_centi <= post_sb_q[BackStages].temp;
    result_q.humidity_q10      <= post_sb_q[BackStages].hum;
    result_q.pressure_div_zero <= post_sb_q[BackStages].dz;
    result_q.pressure_q8       <= post_sb_q[BackStages].dz ? '0
                                  : 32'((r5_sum_q >>> 8) + (p7x <<< 4));
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = result_q;

endmodule

### rtl/thp_sc_checker.sv
module thp_sc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid_o,
  input thp_sc_pkg::thp_out_t            result_o
);
  import thp_sc_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("Block reported busy.");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("Result beat without an input beat at the fixed latency.");

  a_div_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.pressure_div_zero) |-> (result_o.pressure_q8 == '0))
    else $error("Zero divisor flagged but pressure is not zero.");

  a_humidity_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.humidity_q10 <= HumMaxQ10))
    else $error("Humidity beyond its clamp.");

endmodule

bind thp_sensor_compensation_unit thp_sc_checker u_thp_sc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

### dv/thp_sensor_compensation_unit_tb.sv
module thp_sensor_compensation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thp_sc_pkg::*;

  class compensation_checker;
    logic [47:0] calib [6];
    thp_out_t    expected_readings [$];
    int          mismatches;
    int          checked;
    int          div_zero_seen;

    function new();
      foreach (calib[i]) calib[i] = '0;
      mismatches    = 0;
      checked       = 0;
      div_zero_seen = 0;
    endfunction

    function void set_calib(cfg_reg_e idx, logic [47:0] value);
      calib[idx] = value;
    endfunction

    function thp_out_t compensate(thp_in_t raw);
      thp_out_t           res;
      logic signed [31:0] t1, t2, t3, ta, a, d, b, fine, temp;
      logic signed [31:0] h1, h2, h3, h4, h5, h6, v, left, inner, right, s, hh, ah;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] x1, x2, p, n, q, y1, y2;
      t1 = {16'b0, calib[CfgTemp][15:0]};
      t2 = $signed(calib[CfgTemp][31:16]);
      t3 = $signed(calib[CfgTemp][47:32]);
      p1 = {48'b0, calib[CfgPressA][15:0]};
      p2 = $signed(calib[CfgPressA][31:16]);
      p3 = $signed(calib[CfgPressA][47:32]);
      p4 = $signed(calib[CfgPressB][15:0]);
      p5 = $signed(calib[CfgPressB][31:16]);
      p6 = $signed(calib[CfgPressB][47:32]);
      p7 = $signed(calib[CfgPressC][15:0]);
      p8 = $signed(calib[CfgPressC][31:16]);
      p9 = $signed(calib[CfgPressC][47:32]);
      h1 = {24'b0, calib[CfgHumidA][7:0]};
      h2 = $signed(calib[CfgHumidA][23:8]);
      h3 = {24'b0, calib[CfgHumidA][31:24]};
      h4 = $signed(calib[CfgHumidB][15:0]);
      h5 = $signed(calib[CfgHumidB][31:16]);
      h6 = $signed(calib[CfgHumidB][39:32]);

      ta   = {12'b0, raw.temp_raw};
      a    = ((ta >>> 3) - (t1 <<< 1)) * t2;
      a    = a >>> 11;
      d    = (ta >>> 4) - t1;
      b    = d * d;
      b    = (b >>> 12) * t3;
      b    = b >>> 14;
      fine = a + b;
      temp = fine * 32'sd5 + 32'sd128;
      temp = temp >>> 8;

      ah    = {16'b0, raw.humid_raw};
      v     = fine - 32'sd76800;
      left  = (ah <<< 14) - (h4 <<< 20) - h5 * v + 32'sd16384;
      left  = left >>> 15;
      inner = v * h6;
      s     = v * h3;
      s     = (s >>> 11) + 32'sd32768;
      inner = (inner >>> 10) * s;
      inner = inner >>> 10;
      right = (inner + 32'sd2097152) * h2 + 32'sd8192;
      right = right >>> 14;
      v     = left * right;
      s     = v >>> 15;
      hh    = s * s;
      hh    = (hh >>> 7) * h1;
      v     = v - (hh >>> 4);
      if (v < 0) v = 0;
      if (v > 32'sd419430400) v = 32'sd419430400;
      v = v >>> 12;

      x1 = 64'(fine) - 64'sd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) <<< 17);
      x2 = x2 + (p4 <<< 35);
      n  = x1 * x1 * p3;
      x1 = (n >>> 8) + ((x1 * p2) <<< 12);
      x1 = ((64'sd1 <<< 47) + x1) * p1;
      x1 = x1 >>> 33;

      res.temperature_centi = temp;
      res.humidity_q10      = v[16:0];
      if (x1 == 0) begin
        res.pressure_q8       = '0;
        res.pressure_div_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - 64'($signed({44'b0, raw.press_raw}));
        n = ((p <<< 31) - x2) * 64'sd3125;
        if (n == {1'b1, 63'b0} && x1 == -64'sd1) p = n;
        else p = n / x1;
        q  = p >>> 13;
        y1 = p9 * q * q;
        y1 = y1 >>> 25;
        y2 = p8 * p;
        y2 = y2 >>> 19;
        p  = p + y1 + y2;
        p  = (p >>> 8) + (p7 <<< 4);
        res.pressure_q8       = p[31:0];
        res.pressure_div_zero = 1'b0;
      end
      return res;
    endfunction

    function void note_input(thp_in_t raw);
      expected_readings.push_back(compensate(raw));
    endfunction

    function void check_result(thp_out_t got);
      thp_out_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", got);
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      if (want.pressure_div_zero) div_zero_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected temp %0d hum %0d press %0d dz %0b, got %0d %0d %0d %0b",
                   want.temperature_centi, want.humidity_q10, want.pressure_q8,
                   want.pressure_div_zero, got.temperature_centi, got.humidity_q10,
                   got.pressure_q8, got.pressure_div_zero);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  thp_in_t             in_item_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                result_valid_o;
  thp_out_t            result_o;

  compensation_checker checker_h = new();
  int                  max_gap;
  int                  items_sent;

  thp_sensor_compensation_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) checker_h.check_result(result_o);
  end

  task automatic write_calib(cfg_reg_e idx, logic [47:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    checker_h.set_calib(idx, value);
    @(posedge clk_i);
  endtask

  task automatic load_calib(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc, logic [31:0] ha, logic [39:0] hb);
    while (checker_h.expected_readings.size() != 0) @(posedge clk_i);
    write_calib(CfgTemp, t);
    write_calib(CfgPressA, pa);
    write_calib(CfgPressB, pb);
    write_calib(CfgPressC, pc);
    write_calib(CfgHumidA, {16'b0, ha});
    write_calib(CfgHumidB, {8'b0, hb});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_reading(thp_in_t raw);
    int  gap;
    bit  taken;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    in_item_i <= raw;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    checker_h.note_input(raw);
    items_sent++;
  endtask

  function automatic thp_in_t random_reading();
    thp_in_t r;
    r = thp_in_t'(56'({$urandom, $urandom}));
    if ($urandom_range(3, 0) != 0) begin
      r.temp_raw  = 20'($urandom_range(600000, 400000));
      r.press_raw = 20'($urandom_range(500000, 250000));
      r.humid_raw = 16'($urandom_range(45000, 20000));
    end
    return r;
  endfunction

  task automatic run_phase(int count);
    thp_in_t edges [8];
    edges[0] = '{20'h0, 20'h0, 16'h0};
    edges[1] = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF};
    edges[2] = '{20'h0, 20'hFFFFF, 16'h0};
    edges[3] = '{20'hFFFFF, 20'h0, 16'hFFFF};
    edges[4] = '{20'd519888, 20'd415148, 16'd30000};
    edges[5] = '{20'h80000, 20'h80000, 16'h8000};
    edges[6] = '{20'h7FFFF, 20'h7FFFF, 16'h7FFF};
    edges[7] = '{20'd1, 20'd1, 16'd1};
    max_gap = ($urandom_range(2, 0) == 0) ? 0 : 10;
    foreach (edges[i]) send_reading(edges[i]);
    repeat (count) send_reading(random_reading());
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgTemp;
    cfg_wdata_i = '0;
    items_sent  = 0;
    max_gap     = 10;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_phase(150);
    load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500},
               {8'd0, 16'd362, 8'd75}, {8'd30, 16'd50, 16'd324});
    run_phase(300);
    load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd0},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500},
               {8'd0, 16'd362, 8'd75}, {8'd30, 16'd50, 16'd324});
    run_phase(100);
    load_calib('1, '1, '1, '1, '1, '1);
    run_phase(150);
    load_calib(48'h8000_8000_FFFF, 48'h8000_8000_FFFF, 48'h8000_8000_8000,
               48'h8000_8000_8000, 32'hFF80_00FF, 40'h80_8000_8000);
    run_phase(150);
    load_calib(48'h7FFF_7FFF_0000, 48'h7FFF_7FFF_0001, 48'h7FFF_7FFF_7FFF,
               48'h7FFF_7FFF_7FFF, 32'h007F_FF00, 40'h7F_7FFF_7FFF);
    run_phase(150);
    repeat (4) begin
      load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 $urandom, 40'({$urandom, $urandom}));
      run_phase(150);
    end

    while (checker_h.expected_readings.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Sent %0d readings over 10 calibration sets; %0d results checked, %0d div-zero.",
             items_sent, checker_h.checked, checker_h.div_zero_seen);
    if (checker_h.mismatches == 0 && checker_h.expected_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", checker_h.mismatches,
               checker_h.expected_readings.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", checker_h.expected_readings.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/thp_sc_pkg.sv
rtl/thp_sensor_compensation_unit.sv
rtl/thp_sc_checker.sv
dv/thp_sensor_compensation_unit_tb.sv
